// File: sv/pfr_pkg.sv
// package for the page frame replacement block
// shared constants and the cell control and status structs; no dependencies
`default_nettype none
package pfr_pkg;
  localparam int Frames = 16;
  localparam int PageShift = 12;
  localparam int StampBits = 32;
  localparam int AddrBits = 32;
  localparam int PageBits = AddrBits - PageShift;
  localparam int IdxBits = $clog2(Frames);
  localparam int CntBits = $clog2(Frames + 1);
  localparam int FrameOutBits = 4;
  localparam int VictimBits = 20;
  localparam int CfgBits = 5;

  localparam logic CfgPolicy = 1'b0;
  localparam logic CfgFrames = 1'b1;

  localparam logic PolLru = 1'b0;
  localparam logic PolClock = 1'b1;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [PageBits-1:0]  page;
    logic [IdxBits-1:0]   sel;
    logic                 wr_en;   // write selected cell with new page
    logic                 touch;   // refresh stamp/ref on selected cell
    logic                 set_dirty;
    logic                 clr_ref;  // clear ref bit on selected cell
    logic [StampBits-1:0] stamp;
  } cell_ctl_t;

  // per cell status seen by the controller
  typedef struct packed {
    logic                 valid;
    logic                 match;
    logic                 refd;
    logic                 dirty;
    logic [PageBits-1:0]  page;
    logic [StampBits-1:0] stamp;
  } cell_stat_t;
endpackage
`default_nettype wire

// File: sv/page_frame_replacement.sv
// top level of the page frame replacement block
// depends on pfr_pkg and pfr_cell
//
// usage: pulse start with in_virtual_address/in_is_write while busy is low.
// the access is registered, then its page is compared against every cell
// in parallel. a hit or a free-frame fill is written in the compare state.
// on a full table the victim is found by a walk over the cells, one cell
// a cycle: lru scans frames_in_use cells, clock advances the hand one
// cell a cycle until it finds a clear reference bit. the result shows for
// one cycle with out_valid; the receiver cannot stall, and busy drops in
// that same cycle.
// reset empties every frame, zeroes the stamp counter and the clock hand,
// and sets policy lru with 16 frames. configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
`default_nettype none
module page_frame_replacement (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  [pfr_pkg::AddrBits-1:0] in_virtual_address,
  input  wire                          in_is_write,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [3:0]                   out_frame,
  output logic                         out_evicted,
  output logic [19:0]                  out_victim_page,
  output logic                         out_victim_dirty,
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire  [pfr_pkg::CfgBits-1:0]  cfg_data
);
  import pfr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_LOOK = 4'b0010, S_WALK = 4'b0100, S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic policy_r;
  logic [CntBits-1:0] nfr_r;
  logic [StampBits-1:0] acc_r;
  logic [IdxBits-1:0] hand_r, cur_r, best_r;
  logic [PageBits-1:0] page_r;
  logic wr_r;
  logic [StampBits-1:0] best_stamp_r;
  cell_ctl_t ctl;
  cell_stat_t stat [Frames];

  // active frame count clamp
  logic [CntBits-1:0] n;
  always_comb begin
    if (nfr_r == '0) n = CntBits'(1);
    else if (nfr_r > CntBits'(Frames)) n = CntBits'(Frames);
    else n = nfr_r;
  end

  // cell row
  for (genvar g = 0; g < Frames; g++) begin : g_cell
    pfr_cell u_cell (.clk(clk), .rst_n(rst_n), .my_idx(IdxBits'(g)),
                     .ctl(ctl), .stat(stat[g]));
  end

  // lowest matching and lowest free among active cells
  logic hit_f, free_f;
  logic [IdxBits-1:0] hit_i, free_i;
  always_comb begin
    hit_f = 1'b0; free_f = 1'b0; hit_i = '0; free_i = '0;
    for (int i = Frames - 1; i >= 0; i--) begin
      if (CntBits'(i) < n) begin
        if (stat[i].match) begin hit_f = 1'b1; hit_i = IdxBits'(i); end
        if (!stat[i].valid) begin free_f = 1'b1; free_i = IdxBits'(i); end
      end
    end
  end

  logic [IdxBits-1:0] cur_inc, last;
  logic cur_last;
  assign last = IdxBits'(n - CntBits'(1));
  assign cur_last = (cur_r == last);
  assign cur_inc = cur_last ? '0 : cur_r + IdxBits'(1);

  logic [StampBits-1:0] acc_inc;
  assign acc_inc = (acc_r == '1) ? acc_r : acc_r + StampBits'(1);

  assign busy = (state_r != S_IDLE);

  // controller
  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.page = page_r;
    ctl.stamp = acc_r;
    ctl.set_dirty = wr_r;
    ctl.sel = cur_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_LOOK;
      S_LOOK: begin
        if (hit_f) begin
          ctl.sel = hit_i; ctl.touch = 1'b1; state_nxt = S_DONE;
        end else if (free_f) begin
          ctl.sel = free_i; ctl.wr_en = 1'b1; state_nxt = S_DONE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (policy_r == PolClock) begin
          if (stat[cur_r].refd) ctl.clr_ref = 1'b1;
          else begin ctl.wr_en = 1'b1; state_nxt = S_DONE; end
        end else if (cur_last) begin
          ctl.wr_en = 1'b1; state_nxt = S_DONE;
          if (stat[cur_r].stamp >= best_stamp_r && cur_r != '0) ctl.sel = best_r;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; policy_r <= PolLru; nfr_r <= CntBits'(Frames);
      acc_r <= '0; hand_r <= '0; out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == S_DONE);
      if (cfg_we && state_r == S_IDLE) begin
        if (cfg_index == CfgPolicy) policy_r <= cfg_data[0];
        else nfr_r <= cfg_data;
      end
      if (ctl.wr_en || ctl.touch) acc_r <= acc_inc;
      if (state_r == S_LOOK && !hit_f && !free_f)
        cur_r <= (policy_r == PolClock) ? ((CntBits'(hand_r) >= n) ? '0 : hand_r) : '0;
      if (state_r == S_WALK) begin
        if (policy_r == PolClock) begin
          cur_r <= cur_inc;
          if (ctl.wr_en) hand_r <= cur_inc;
        end else begin
          cur_r <= cur_inc;
          if (cur_r == '0 || stat[cur_r].stamp < best_stamp_r) begin
            best_r <= cur_r; best_stamp_r <= stat[cur_r].stamp;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      page_r <= in_virtual_address[AddrBits-1:PageShift];
      wr_r <= in_is_write;
    end
    if (ctl.wr_en || ctl.touch) begin
      out_hit <= ctl.touch;
      out_frame <= FrameOutBits'(ctl.sel);
      out_evicted <= (state_r == S_WALK);
      out_victim_page <= (state_r == S_WALK) ? VictimBits'(stat[ctl.sel].page) : '0;
      out_victim_dirty <= (state_r == S_WALK) && stat[ctl.sel].dirty;
    end
  end
endmodule
`default_nettype wire

// File: sv/pfr_cell.sv
// one frame cell: page, stamp, valid, dirty and reference bits
// depends on pfr_pkg
`default_nettype none
module pfr_cell (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire  [pfr_pkg::IdxBits-1:0] my_idx,
  input  pfr_pkg::cell_ctl_t       ctl,
  output pfr_pkg::cell_stat_t      stat
);
  import pfr_pkg::*;

  logic                 valid_r, dirty_r, ref_r;
  logic [PageBits-1:0]  page_r;
  logic [StampBits-1:0] stamp_r;
  logic                 me;

  assign me = (ctl.sel == my_idx);

  // control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      ref_r   <= 1'b0;
    end else if (me) begin
      if (ctl.wr_en) begin
        valid_r <= 1'b1;
        dirty_r <= ctl.set_dirty;
        ref_r   <= 1'b1;
      end else if (ctl.touch) begin
        ref_r <= 1'b1;
        if (ctl.set_dirty) dirty_r <= 1'b1;
      end else if (ctl.clr_ref) begin
        ref_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (me && ctl.wr_en) page_r <= ctl.page;
    if (me && (ctl.wr_en || ctl.touch)) stamp_r <= ctl.stamp;
  end

  assign stat.valid = valid_r;
  assign stat.match = valid_r && (page_r == ctl.page);
  assign stat.refd  = ref_r;
  assign stat.dirty = dirty_r;
  assign stat.page  = page_r;
  assign stat.stamp = stamp_r;
endmodule
`default_nettype wire

// File: tb/tb.sv
// testbench for page_frame_replacement: directed and random memory accesses
// with a behavioral frame table predictor; depends on pfr_pkg and the rtl
`timescale 1ns / 100ps
module tb;
  import pfr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [AddrBits-1:0] in_virtual_address = '0;
  logic in_is_write = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CfgPolicy;
  logic [CfgBits-1:0] cfg_data = '0;
  wire busy, out_valid, out_hit, out_evicted, out_victim_dirty;
  wire [3:0] out_frame;
  wire [19:0] out_victim_page;

  page_frame_replacement DUT (.*);

  always #6 clk = ~clk;

  typedef struct packed {
    logic [AddrBits-1:0] addr;
    logic                wr;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  frame;
    logic        evicted;
    logic [19:0] vpage;
    logic        vdirty;
  } outcome_t;

  access_t  pending_q[$];
  outcome_t outcome_q[$];

  // predictor copy of the frame table
  logic                 pol;
  logic [4:0]           nframes;
  logic                 f_valid[Frames];
  logic [PageBits-1:0]  f_page[Frames];
  logic                 f_dirty[Frames];
  logic [StampBits-1:0] f_stamp[Frames];
  logic                 f_ref[Frames];
  logic [StampBits-1:0] acc_cnt;
  int                   hand;

  int errors = 0, accepted = 0, results = 0, evictions = 0, idle_cycles = 0;
  bit random_idle = 1'b1;

  function automatic logic [StampBits-1:0] take_stamp();
    logic [StampBits-1:0] s;
    s = acc_cnt;
    if (acc_cnt != '1) acc_cnt = acc_cnt + 1;
    return s;
  endfunction

  function automatic outcome_t predict_access(access_t a);
    outcome_t o;
    logic [PageBits-1:0] pg;
    int n, f, i;
    bit found;
    pg = a.addr[AddrBits-1:PageShift];
    n = (nframes == 0) ? 1 : (nframes > Frames) ? Frames : nframes;
    o = '0;
    f = 0;
    found = 0;
    for (i = 0; i < n; i++)
      if (!found && f_valid[i] && f_page[i] == pg) begin
        found = 1;
        f = i;
      end
    if (found) begin
      o.hit = 1'b1;
      f_stamp[f] = take_stamp();
      f_ref[f] = 1'b1;
    end else begin
      for (i = 0; i < n; i++)
        if (!found && !f_valid[i]) begin
          found = 1;
          f = i;
        end
      if (!found) begin
        if (pol == PolClock) begin
          if (hand >= n) hand = 0;
          while (f_ref[hand]) begin
            f_ref[hand] = 1'b0;
            hand = (hand + 1) % n;
          end
          f = hand;
          hand = (hand + 1) % n;
        end else begin
          f = 0;
          for (i = 1; i < n; i++)
            if (f_stamp[i] < f_stamp[f]) f = i;
        end
        o.evicted = 1'b1;
        o.vpage = f_page[f][19:0];
        o.vdirty = f_dirty[f];
      end
      f_valid[f] = 1'b1;
      f_page[f] = pg;
      f_dirty[f] = 1'b0;
      f_stamp[f] = take_stamp();
      f_ref[f] = 1'b1;
    end
    if (a.wr) f_dirty[f] = 1'b1;
    o.frame = f[3:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // driver: start stays high across back-to-back transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        accepted++;
        outcome_q.push_back(predict_access({in_virtual_address, in_is_write}));
      end
      if ((!start || !busy) && pending_q.size() > 0 &&
          !(random_idle && $urandom_range(99) < 33)) begin
        access_t a;
        a = pending_q.pop_front();
        start <= 1'b1;
        in_virtual_address <= a.addr;
        in_is_write <= a.wr;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      outcome_t e;
      results++;
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = outcome_q.pop_front();
        if (e.evicted) evictions++;
        if (out_hit !== e.hit) report_mismatch("hit", out_hit, e.hit);
        if (out_frame !== e.frame) report_mismatch("frame", out_frame, e.frame);
        if (out_evicted !== e.evicted) report_mismatch("evicted", out_evicted, e.evicted);
        if (out_victim_page !== e.vpage)
          report_mismatch("victim_page", out_victim_page, e.vpage);
        if (out_victim_dirty !== e.vdirty)
          report_mismatch("victim_dirty", out_victim_dirty, e.vdirty);
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("** page_frame_replacement: FAILED **");
      $finish;
    end
  end

  task automatic write_cfg(logic idx, logic [CfgBits-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgPolicy) pol = val[0];
    else nframes = val;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || start || outcome_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random accesses over a small page pool so hits and evictions both occur
  task automatic random_phase(int count, int pool);
    access_t a;
    for (int k = 0; k < count; k++) begin
      a.addr = {$urandom};
      if ($urandom_range(9) < 8)
        a.addr[31:12] = 20'(($urandom_range(pool - 1) * 32'h1357) & 20'hFFFFF);
      a.wr = $urandom_range(1);
      pending_q.push_back(a);
    end
    drain();
  endtask

  initial begin
    access_t a;
    pol = PolLru;
    nframes = 16;
    acc_cnt = '0;
    hand = 0;
    for (int i = 0; i < Frames; i++) begin
      f_valid[i] = 0; f_page[i] = '0; f_dirty[i] = 0; f_stamp[i] = '0; f_ref[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed: fill, hit, evict, address extremes, writes
    write_cfg(CfgFrames, 5'd2);
    a = {32'h0000_0000, 1'b0}; pending_q.push_back(a);
    a = {32'hFFFF_FFFF, 1'b1}; pending_q.push_back(a);
    a = {32'h0000_0FFF, 1'b1}; pending_q.push_back(a);
    a = {32'h5555_5000, 1'b0}; pending_q.push_back(a);
    a = {32'hAAAA_AFFF, 1'b1}; pending_q.push_back(a);
    a = {32'h5555_5123, 1'b0}; pending_q.push_back(a);
    a = {32'h0000_1000, 1'b0}; pending_q.push_back(a);
    drain();
    // frame count zero acts as one, clock policy
    write_cfg(CfgFrames, 5'd0);
    write_cfg(CfgPolicy, PolClock);
    for (int k = 0; k < 4; k++) begin
      a = {32'h1000 * k, k[0]}; pending_q.push_back(a);
    end
    drain();
    // count above the table size acts as the full table
    write_cfg(CfgFrames, 5'd31);
    random_phase(30, 24);
    write_cfg(CfgFrames, 5'd3);
    random_phase(20, 6);
    // random phases across policies and sizes, one long stretch without idling
    write_cfg(CfgPolicy, PolLru);
    write_cfg(CfgFrames, 5'd16);
    random_phase(150, 24);
    random_idle = 1'b0;
    write_cfg(CfgFrames, 5'd7);
    random_phase(100, 12);
    random_idle = 1'b1;
    write_cfg(CfgPolicy, PolClock);
    write_cfg(CfgFrames, 5'd16);
    random_phase(150, 24);
    write_cfg(CfgFrames, 5'd1);
    random_phase(50, 3);
    write_cfg(CfgFrames, 5'd10);
    random_phase(120, 16);
    repeat (50) @(posedge clk);
    $display("covered %0d accesses, %0d results, %0d evictions", accepted, results, evictions);
    $display("both policies, frame counts 0 to 31");
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("** page_frame_replacement: PASSED **");
    end else begin
      $display("** page_frame_replacement: FAILED **");
    end
    $finish;
  end
endmodule

// File: files.f
sv/pfr_pkg.sv
sv/pfr_cell.sv
sv/page_frame_replacement.sv
tb/tb.sv
